// File: hdl/ccl_pkg.sv
// Shared types and constants for the cartridge chunk loader.
// Used by the front parser, the job queue, the result sequencer, the top level and the checker.
// Depends on nothing else.
package ccl_pkg;

    // Width of the file length register and of the byte position counter.
    localparam int LENGTH_BITS = 24;
    // Number of bytes a bank clear covers, reported in the offset field.
    localparam int CLEAR_BYTES = 4096;

    localparam int BANK_W   = 8;
    localparam int OFFSET_W = 24;
    localparam int BYTE_W   = 8;
    localparam int SIZE_W   = 32;

    // Job queue between the parser and the result sequencer.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Four-character tags, first character in the top byte.
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_AMS  = 32'h414D_5321;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [7:0]  CHAR_C    = 8'h63;
    localparam logic [7:0]  CHAR_B    = 8'h62;
    localparam logic [7:0]  CHAR_ZERO = 8'h30;

    // Smallest file that can hold the fixed header.
    localparam int HEADER_BYTES = 12;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_EJECT = 3'd0,
        KIND_CLEAR = 3'd1,
        KIND_WRITE = 3'd2,
        KIND_DONE  = 3'd3,
        KIND_ERROR = 3'd4
    } t_kind;

    // One result item.
    typedef struct packed {
        t_kind                 kind;
        logic [BANK_W-1:0]     bank;
        logic [OFFSET_W-1:0]   offset;
        logic [BYTE_W-1:0]     data;
    } t_result;

    // Everything one input byte produces. The second result, when there is
    // one, is always a plain "done".
    typedef struct packed {
        t_result res;
        logic    with_done;
    } t_job;

endpackage

// File: hdl/ccl_front.sv
// Front parser of the cartridge chunk loader: accepts file bytes, tracks the
// RIFF/chunk structure and produces one job per byte that has results.
// Depends on ccl_pkg.
module ccl_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [ccl_pkg::LENGTH_BITS-1:0]    i_file_length,
    input  logic                               i_valid,
    input  logic [ccl_pkg::BYTE_W-1:0]         i_byte,
    input  logic                               i_q_ready,
    output logic                               o_ready,
    output logic                               o_push,
    output ccl_pkg::t_job                      o_job
);
    import ccl_pkg::*;

    typedef enum logic [6:0] {
        PH_HDR   = 7'b0000001,
        PH_ID    = 7'b0000010,
        PH_SKIP  = 7'b0000100,
        PH_SIZE  = 7'b0001000,
        PH_DATA  = 7'b0010000,
        PH_DONE  = 7'b0100000,
        PH_FAULT = 7'b1000000
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [LENGTH_BITS-1:0] r_pos, n_pos;
    logic [31:0]            r_window, n_window;
    logic [BANK_W-1:0]      r_bank, n_bank;
    logic [SIZE_W-1:0]      r_left, n_left;
    logic [OFFSET_W-1:0]    r_wp, n_wp;
    logic                   r_fault, n_fault;

    logic                   accept;
    logic [31:0]            win_new;
    logic [LENGTH_BITS:0]   pos_p1;
    logic [LENGTH_BITS:0]   pos_p9;
    logic                   near_end;
    logic                   at_end;
    logic signed [12:0]     digit_hi, digit_lo, bank_num;
    logic                   bank_bad;
    logic [SIZE_W-1:0]      size_new;
    logic [SIZE_W-1:0]      left_dec;
    logic                   chunk_start;
    logic                   add_done;
    logic                   push;
    t_job                   job;

    assign accept  = i_valid & i_q_ready;
    assign o_ready = i_q_ready;
    assign o_push  = push;
    assign o_job   = job;

    // Values shared by several phases.
    assign win_new  = {r_window[23:0], i_byte};
    assign pos_p1   = {1'b0, r_pos} + (LENGTH_BITS+1)'(1);
    assign pos_p9   = {1'b0, r_pos} + (LENGTH_BITS+1)'(9);
    assign near_end = pos_p9 >= {1'b0, i_file_length};
    assign at_end   = pos_p1 >= {1'b0, i_file_length};

    // Bank number from two decimal digits; out of range when negative or above 255.
    assign digit_hi = $signed({5'b0, win_new[15:8]}) - $signed({5'b0, CHAR_ZERO});
    assign digit_lo = $signed({5'b0, win_new[7:0]}) - $signed({5'b0, CHAR_ZERO});
    assign bank_num = (digit_hi <<< 3) + (digit_hi <<< 1) + digit_lo;
    assign bank_bad = bank_num[12] | (bank_num[11:8] != 4'd0);

    // Little-endian size gathering and data countdown.
    assign size_new = r_left | (SIZE_W'(i_byte) << {r_wp[1:0], 3'b000});
    assign left_dec = r_left - SIZE_W'(1);

    // Next-state and job generation for one accepted byte.
    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_window    = r_window;
        n_bank      = r_bank;
        n_left      = r_left;
        n_wp        = r_wp;
        n_fault     = r_fault;
        chunk_start = 1'b0;
        add_done    = 1'b0;
        push        = 1'b0;
        job         = '0;

        if (accept && r_phase != PH_DONE && r_phase != PH_FAULT) begin
            if (r_phase == PH_HDR && r_pos == '0 &&
                i_file_length < LENGTH_BITS'(HEADER_BYTES)) begin
                // File too short for the header.
                push           = 1'b1;
                job.res.kind   = KIND_ERROR;
                n_phase        = PH_FAULT;
            end else if (r_pos < i_file_length) begin
                n_window = win_new;
                n_pos    = pos_p1[LENGTH_BITS-1:0];
                case (r_phase)
                    PH_HDR: begin
                        if (r_pos == LENGTH_BITS'(3) && win_new != TAG_RIFF) begin
                            n_fault = 1'b1;
                        end
                        if (r_pos == LENGTH_BITS'(11)) begin
                            push = 1'b1;
                            if (r_fault || win_new != TAG_AMS) begin
                                job.res.kind = KIND_ERROR;
                                n_phase      = PH_FAULT;
                            end else begin
                                job.res.kind = KIND_EJECT;
                                n_fault      = 1'b0;
                                chunk_start  = 1'b1;
                            end
                        end
                    end
                    PH_ID: begin
                        if (r_wp < OFFSET_W'(3)) begin
                            n_wp = r_wp + OFFSET_W'(1);
                        end else if (r_pos == LENGTH_BITS'(15) && win_new == TAG_FMT) begin
                            n_phase = PH_SKIP;
                            n_wp    = '0;
                        end else if (win_new[31:24] != CHAR_C || win_new[23:16] != CHAR_B) begin
                            push         = 1'b1;
                            job.res.kind = KIND_ERROR;
                            n_phase      = PH_FAULT;
                        end else begin
                            n_fault = bank_bad;
                            n_bank  = bank_bad ? '0 : bank_num[BANK_W-1:0];
                            n_phase = PH_SIZE;
                            n_wp    = '0;
                            n_left  = '0;
                        end
                    end
                    PH_SKIP: begin
                        if (r_wp < OFFSET_W'(3)) begin
                            n_wp = r_wp + OFFSET_W'(1);
                        end else begin
                            chunk_start = 1'b1;
                        end
                    end
                    PH_SIZE: begin
                        n_left = size_new;
                        if (r_wp < OFFSET_W'(3)) begin
                            n_wp = r_wp + OFFSET_W'(1);
                        end else if (r_fault ||
                                     size_new > SIZE_W'(i_file_length)) begin
                            push         = 1'b1;
                            job.res.kind = KIND_ERROR;
                            n_phase      = PH_FAULT;
                        end else begin
                            push           = 1'b1;
                            job.res.kind   = KIND_CLEAR;
                            job.res.bank   = r_bank;
                            job.res.offset = OFFSET_W'(CLEAR_BYTES);
                            if (size_new == '0) begin
                                chunk_start = 1'b1;
                            end else begin
                                n_phase = PH_DATA;
                                n_wp    = '0;
                                add_done = at_end;
                            end
                        end
                    end
                    PH_DATA: begin
                        push           = 1'b1;
                        job.res.kind   = KIND_WRITE;
                        job.res.bank   = r_bank;
                        job.res.offset = r_wp;
                        job.res.data   = i_byte;
                        n_wp           = r_wp + OFFSET_W'(1);
                        n_left         = left_dec;
                        if (left_dec == '0) begin
                            chunk_start = 1'b1;
                        end else begin
                            add_done = at_end;
                        end
                    end
                    default: begin
                    end
                endcase

                // A new chunk begins at the next byte unless too little file is left.
                if (chunk_start) begin
                    if (near_end) begin
                        add_done = 1'b1;
                    end else begin
                        n_phase  = PH_ID;
                        n_wp     = '0;
                        n_window = '0;
                    end
                end

                // The end of the parse rides on the job, or forms one of its own.
                if (add_done) begin
                    n_phase = PH_DONE;
                    if (push) begin
                        job.with_done = 1'b1;
                    end else begin
                        push         = 1'b1;
                        job.res.kind = KIND_DONE;
                    end
                end
            end
        end
    end

    // Parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR;
            r_pos    <= '0;
            r_window <= '0;
            r_bank   <= '0;
            r_left   <= '0;
            r_wp     <= '0;
            r_fault  <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_window <= n_window;
            r_bank   <= n_bank;
            r_left   <= n_left;
            r_wp     <= n_wp;
            r_fault  <= n_fault;
        end
    end

endmodule

// File: hdl/ccl_queue.sv
// Short job queue between the parser and the result sequencer, so that each
// side can stall on its own. Depends on ccl_pkg.
module ccl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ccl_pkg::t_job  i_job,
    input  logic           i_pop,
    output logic           o_not_full,
    output logic           o_not_empty,
    output ccl_pkg::t_job  o_job
);
    import ccl_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic               do_push, do_pop;

    assign o_not_full  = r_count != Q_CNT_W'(Q_DEPTH);
    assign o_not_empty = r_count != '0;
    assign o_job       = r_mem[r_rd_ptr];

    assign do_push = i_push & o_not_full;
    assign do_pop  = i_pop & o_not_empty;

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + Q_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + Q_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: hdl/ccl_back.sv
// Result sequencer of the cartridge chunk loader: takes jobs from the queue
// into an output register and hands out one or two results per job.
// Depends on ccl_pkg.
module ccl_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_not_empty,
    input  ccl_pkg::t_job     i_job,
    output logic              o_pop,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output ccl_pkg::t_result  o_result,
    output logic              o_out_last
);
    import ccl_pkg::*;

    t_job    r_job;
    logic    r_valid, n_valid;
    logic    r_second, n_second;
    logic    taken;
    logic    job_finished;
    t_result done_res;

    assign taken        = r_valid & i_out_ready;
    assign job_finished = taken & (r_second | ~r_job.with_done);
    assign o_pop        = i_q_not_empty & (~r_valid | job_finished);

    // The trailing "done" result of a two-result job.
    always_comb begin
        done_res      = '0;
        done_res.kind = KIND_DONE;
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_second ? done_res : r_job.res;
    assign o_out_last  = r_second | ~r_job.with_done;

    // Output register control.
    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        if (o_pop) begin
            n_valid  = 1'b1;
            n_second = 1'b0;
        end else if (job_finished) begin
            n_valid  = 1'b0;
            n_second = 1'b0;
        end else if (taken) begin
            n_second = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

endmodule

// File: hdl/cartridge_chunk_loader.sv
// Cartridge chunk loader: parses a RIFF "AMS!" cartridge image byte by byte.
// Throughput: one file byte per cycle while the queue has room; a byte with two results holds the output
// for both of its results in turn, and a four-job queue lets the parser run ahead while the output side stalls.
// Path: with nothing queued, the job of a byte is written into the queue and then loaded into the
// output register, from which its first result is offered.
// Reset: synchronous, active low; clears the parse state, the queue, the output and file length.
// Depends on ccl_pkg, ccl_front, ccl_queue and ccl_back.
module cartridge_chunk_loader (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [ccl_pkg::LENGTH_BITS-1:0]  i_cfg_wr_data,  // file_length
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // [7:0] data_byte
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [39:0]                      m_axis_tdata,   // [7:0] bank, [31:8] offset, [39:32] data
    output logic [2:0]                       m_axis_tuser,   // [2:0] kind
    output logic                             m_axis_tlast    // last_of_run
);
    import ccl_pkg::*;

    logic [LENGTH_BITS-1:0] r_file_length;
    logic                   q_not_full, q_not_empty;
    logic                   push, pop;
    t_job                   front_job, head_job;
    t_result                result;

    // File length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_length <= '0;
        end else if (i_cfg_wr_en) begin
            r_file_length <= i_cfg_wr_data;
        end
    end

    ccl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_file_length (r_file_length),
        .i_valid       (s_axis_tvalid),
        .i_byte        (s_axis_tdata),
        .i_q_ready     (q_not_full),
        .o_ready       (s_axis_tready),
        .o_push        (push),
        .o_job         (front_job)
    );

    ccl_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_job       (front_job),
        .i_pop       (pop),
        .o_not_full  (q_not_full),
        .o_not_empty (q_not_empty),
        .o_job       (head_job)
    );

    ccl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_job         (head_job),
        .o_pop         (pop),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_result      (result),
        .o_out_last    (m_axis_tlast)
    );

    // Pack the result, first field in the lowest bits.
    assign m_axis_tdata = {result.data, result.offset, result.bank};
    assign m_axis_tuser = result.kind;

endmodule

// File: hdl/ccl_checker.sv
// Port-level checks for the cartridge chunk loader, attached by a bind below.
// Depends on ccl_pkg and the top level's ports.
module ccl_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [39:0]                      m_axis_tdata,
    input  logic [2:0]                       m_axis_tuser,
    input  logic                             m_axis_tlast
);
    import ccl_pkg::*;

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Done and error always close the run of results for their byte.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_DONE || m_axis_tuser == KIND_ERROR)
            |-> m_axis_tlast)
        else $error("done or error without last flag");

    // A bank clear reports the cleared size.
    a_clear_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_CLEAR
            |-> m_axis_tdata[31:8] == OFFSET_W'(CLEAR_BYTES) && m_axis_tdata[39:32] == '0)
        else $error("bank clear with wrong size or data");

    // Nothing is offered right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered after reset");

endmodule

bind cartridge_chunk_loader ccl_checker u_ccl_checker (.*);
